[rtl/clp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the clip launch phase tracker
package clp_pkg;

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_LED   = 2'd0,
    CMD_START = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // configuration register indexes
  localparam logic [1:0] REG_QUEUED_CH  = 2'd0;
  localparam logic [1:0] REG_PLAYING_CH = 2'd1;
  localparam logic [1:0] REG_MODE_CODE  = 2'd2;

  // midi status types
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

  // pad grid decode: note = 92 - 8*track + slot, top note of the grid is 99
  localparam logic [7:0] PAD_TOP_NOTE = 8'd99;

  // reset values of the configuration registers
  localparam logic [3:0] QUEUED_CH_RST  = 4'd1;
  localparam logic [3:0] PLAYING_CH_RST = 4'd0;
  localparam logic [7:0] MODE_CODE_RST  = 8'd0;

  // field widths
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned DVD_W   = TIME_W + FRAC_W;
  localparam int unsigned PHASE_W = TIME_W + 1;

  // remainder unit: one dividend bit per cycle
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  // job queue between front and back
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JPTR_W    = $clog2(JOB_DEPTH);

  // back state machine
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_SUM  = 2'd2
  } back_state_e;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic              query_ok;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] loop_base;
    logic [TIME_W-1:0] loop_length;
  } job_t;

  // queue status seen by the back
  typedef struct packed {
    logic empty;
    job_t head;
  } jq_status_t;

endpackage

[rtl/clp_front.sv]
`timescale 1ns / 1ps
// front part: configuration, per-track launch state and query classification
module clp_front import clp_pkg::*; #(
  parameter int unsigned TRACK_COUNT = 4,
  parameter int unsigned SLOT_COUNT  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              accept_i,
  input  logic [1:0]        command_i,
  input  logic [7:0]        status_byte_i,
  input  logic [7:0]        note_number_i,
  input  logic [7:0]        velocity_i,
  input  logic [31:0]       pulse_count_i,
  input  logic              transport_running_i,
  input  logic [7:0]        ui_mode_i,
  input  logic [1:0]        query_track_i,
  input  logic [31:0]       loop_start_i,
  input  logic [31:0]       loop_length_i,
  output job_t              job_o
);

  localparam int unsigned TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam logic [4:0] TrackLim = 5'(TRACK_COUNT);
  localparam logic [3:0] SlotLim  = 4'(SLOT_COUNT);

  // configuration registers
  logic [3:0] qch_q, pch_q;
  logic [7:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qch_q  <= QUEUED_CH_RST;
      pch_q  <= PLAYING_CH_RST;
      mode_q <= MODE_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_QUEUED_CH:  qch_q  <= cfg_data_i[3:0];
        REG_PLAYING_CH: pch_q  <= cfg_data_i[3:0];
        REG_MODE_CODE:  mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-track state
  logic [TRACK_COUNT-1:0] id_q, id_d, play_q, play_d, anchk_q, anchk_d;
  logic [TRACK_COUNT-1:0] pend_q, pend_d, stopw_q, stopw_d;
  logic [SLOT_W-1:0]      cur_q[TRACK_COUNT], cur_d[TRACK_COUNT];
  logic [SLOT_W-1:0]      pslot_q[TRACK_COUNT], pslot_d[TRACK_COUNT];
  logic [TIME_W-1:0]      anchor_q[TRACK_COUNT], anchor_d[TRACK_COUNT];

  // pad decode
  cmd_e              cmd;
  logic [7:0]        diff;
  logic [4:0]        pad_track;
  logic [SLOT_W-1:0] slot;
  logic              pad_ok, type_ok, msg_ok, note_on;
  logic [3:0]        ch;
  logic [TW-1:0]     idx;

  assign cmd       = cmd_e'(command_i);
  assign diff      = PAD_TOP_NOTE - note_number_i;
  assign pad_track = diff[7:3];
  assign slot      = ~diff[2:0];
  assign pad_ok    = (note_number_i <= PAD_TOP_NOTE) && (pad_track < TrackLim)
                     && ({1'b0, slot} < SlotLim);
  assign type_ok   = (status_byte_i[7:4] == STATUS_NOTE_ON)
                     || (status_byte_i[7:4] == STATUS_NOTE_OFF);
  assign msg_ok    = type_ok && (ui_mode_i == mode_q) && pad_ok;
  assign note_on   = (status_byte_i[7:4] == STATUS_NOTE_ON) && (velocity_i != 8'd0);
  assign ch        = status_byte_i[3:0];

  // one track is looked at per transaction
  assign idx = (cmd == CMD_QUERY) ? query_track_i[TW-1:0] : pad_track[TW-1:0];

  logic              queued_hit, changed, cur_match;
  assign queued_hit = pend_q[idx] && (pslot_q[idx] == slot);
  assign cur_match  = id_q[idx] && play_q[idx] && (cur_q[idx] == slot);
  assign changed    = !cur_match;

  // state update
  always_comb begin
    id_d     = id_q;
    play_d   = play_q;
    anchk_d  = anchk_q;
    pend_d   = pend_q;
    stopw_d  = stopw_q;
    cur_d    = cur_q;
    pslot_d  = pslot_q;
    anchor_d = anchor_q;
    if (accept_i) begin
      case (cmd)
        CMD_LED: begin
          if (msg_ok) begin
            if (ch == qch_q) begin
              if (note_on) begin
                pend_d[idx]  = 1'b1;
                pslot_d[idx] = slot;
              end
            end else if (ch == pch_q) begin
              if (note_on) begin
                id_d[idx]   = 1'b1;
                play_d[idx] = 1'b1;
                cur_d[idx]  = slot;
                if (transport_running_i && (queued_hit || stopw_q[idx])) begin
                  anchk_d[idx]  = 1'b1;
                  anchor_d[idx] = pulse_count_i;
                end else if (changed) begin
                  anchk_d[idx] = 1'b0;
                end
                pend_d[idx]  = 1'b0;
                stopw_d[idx] = 1'b0;
              end else if (cur_match) begin
                play_d[idx]  = 1'b0;
                anchk_d[idx] = 1'b0;
                stopw_d[idx] = 1'b1;
              end
            end
          end
        end
        CMD_START: begin
          for (int t = 0; t < TRACK_COUNT; t++) begin
            pend_d[t]  = 1'b0;
            stopw_d[t] = 1'b0;
            anchk_d[t] = id_q[t] && play_q[t];
            if (id_q[t] && play_q[t]) begin
              anchor_d[t] = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // track flags, slots and anchors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q     <= '0;
      play_q   <= '0;
      anchk_q  <= '0;
      pend_q   <= '0;
      stopw_q  <= '0;
      cur_q    <= '{default: '0};
      pslot_q  <= '{default: '0};
      anchor_q <= '{default: '0};
    end else begin
      id_q     <= id_d;
      play_q   <= play_d;
      anchk_q  <= anchk_d;
      pend_q   <= pend_d;
      stopw_q  <= stopw_d;
      cur_q    <= cur_d;
      pslot_q  <= pslot_d;
      anchor_q <= anchor_d;
    end
  end

  // query classification
  logic q_ok;
  assign q_ok = (cmd == CMD_QUERY) && ({1'b0, query_track_i} < 3'(TRACK_COUNT))
                && id_q[idx] && play_q[idx] && anchk_q[idx]
                && (loop_length_i != '0) && (pulse_count_i >= anchor_q[idx]);

  assign job_o.query_ok    = q_ok;
  assign job_o.elapsed     = pulse_count_i - anchor_q[idx];
  assign job_o.loop_base   = loop_start_i;
  assign job_o.loop_length = loop_length_i;

endmodule

[rtl/clp_job_queue.sv]
`timescale 1ns / 1ps
// short job queue between the front and the back
module clp_job_queue import clp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  job_t       wr_job_i,
  output logic       full_o,
  input  logic       rd_i,
  output jq_status_t status_o
);

  job_t              mem_q[JOB_DEPTH];
  logic [JPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [JPTR_W:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o          = (cnt_q == (JPTR_W + 1)'(JOB_DEPTH));
  assign status_o.empty  = (cnt_q == '0);
  assign status_o.head   = mem_q[rptr_q];
  assign do_wr           = wr_i && !full_o;
  assign do_rd           = rd_i && !status_o.empty;

  // pointer and fill count
  always_comb begin
    wptr_d = do_wr ? JPTR_W'(wptr_q + 1'b1) : wptr_q;
    rptr_d = do_rd ? JPTR_W'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_job_i;
    end
  end

endmodule

[rtl/clp_back.sv]
`timescale 1ns / 1ps
// back part: bit-serial loop modulo, start offset add and result register
module clp_back import clp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jq_status_t         jq_i,
  output logic               jq_rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic               phase_valid_o,
  output logic [PHASE_W-1:0] phase_value_o
);

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TIME_W-1:0]  rem_q, rem_d, start_q, start_d, len_q, len_d;
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic               out_valid_q, out_valid_d, out_pv_q, out_pv_d;
  logic [PHASE_W-1:0] out_val_q, out_val_d;

  logic take;
  assign take = (state_q == BK_IDLE) && !jq_i.empty && !out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (take && jq_i.head.query_ok) state_d = BK_DIV;
      BK_DIV:  if (cnt_q == LAST_STEP) state_d = BK_SUM;
      BK_SUM:  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // one restoring remainder step
  logic [TIME_W:0]  rem_sh;
  logic             ge;
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, len_q});

  // datapath and result register
  always_comb begin
    jq_rd_o     = take;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    start_d     = start_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    out_pv_d    = out_pv_q;
    out_val_d   = out_val_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BK_IDLE: begin
        if (take) begin
          cnt_d   = '0;
          rem_d   = '0;
          dvd_d   = {jq_i.head.elapsed, FRAC_W'(0)};
          start_d = jq_i.head.loop_base;
          len_d   = jq_i.head.loop_length;
          if (!jq_i.head.query_ok) begin
            out_valid_d = 1'b1;
            out_pv_d    = 1'b0;
            out_val_d   = '0;
          end
        end
      end
      BK_DIV: begin
        cnt_d = CNT_W'(cnt_q + 1'b1);
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
        rem_d = ge ? TIME_W'(rem_sh - {1'b0, len_q}) : rem_sh[TIME_W-1:0];
      end
      BK_SUM: begin
        out_valid_d = 1'b1;
        out_pv_d    = 1'b1;
        out_val_d   = {1'b0, start_q} + {1'b0, rem_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    start_q   <= start_d;
    len_q     <= len_d;
    out_pv_q  <= out_pv_d;
    out_val_q <= out_val_d;
  end

  assign empty_o       = !out_valid_q;
  assign phase_valid_o = out_pv_q;
  assign phase_value_o = out_val_q;

endmodule

[rtl/clip_launch_phase_tracker.sv]
`timescale 1ns / 1ps
// Usage: clip launch phase tracker top level
// Input channel: queue style; a transaction is taken when push is high and full is low.
//   command 0 is a pad led message, 1 a transport start, 2 a phase query.
// Result channel: queue style; the oldest result sits on phase_valid_o/phase_value_o
//   while empty is low and leaves when pop is high.
// Every input transaction gives exactly one result, in order.
// The front applies led messages and transport starts to the track state in the
// accept cycle and classifies queries; a two-entry job queue feeds the back.
// Non-query commands and refused queries pass the queue write and the take; an
//   answered query also takes one remainder step per bit of the 40-bit dividend
//   and then the add.
// The back takes a new job only while idle with an empty result register; the
//   front keeps accepting transactions while the job queue has room.
// When pop stays low the result register holds, the job queue fills and full rises.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect next cycle.
// Reset clears all track state (no slot playing or queued), empties both queues
// and loads the channel and mode registers with their defaults.
module clip_launch_phase_tracker import clp_pkg::*; #(
  parameter int unsigned TRACK_COUNT = 4,
  parameter int unsigned SLOT_COUNT  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         push,
  output logic         full,
  input  logic [1:0]   command_i,
  input  logic [7:0]   status_byte_i,
  input  logic [7:0]   note_number_i,
  input  logic [7:0]   velocity_i,
  input  logic [31:0]  pulse_count_i,
  input  logic         transport_running_i,
  input  logic [7:0]   ui_mode_i,
  input  logic [1:0]   query_track_i,
  input  logic [31:0]  loop_start_i,
  input  logic [31:0]  loop_length_i,
  output logic         empty,
  input  logic         pop,
  output logic         phase_valid_o,
  output logic [32:0]  phase_value_o
);

  job_t       job;
  jq_status_t jq_status;
  logic       accept, jq_rd;

  assign accept = push && !full;

  // front: state tracking and query classification
  clp_front #(
    .TRACK_COUNT(TRACK_COUNT),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .accept_i           (accept),
    .command_i          (command_i),
    .status_byte_i      (status_byte_i),
    .note_number_i      (note_number_i),
    .velocity_i         (velocity_i),
    .pulse_count_i      (pulse_count_i),
    .transport_running_i(transport_running_i),
    .ui_mode_i          (ui_mode_i),
    .query_track_i      (query_track_i),
    .loop_start_i       (loop_start_i),
    .loop_length_i      (loop_length_i),
    .job_o              (job)
  );

  // job queue
  clp_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wr_job_i(job),
    .full_o  (full),
    .rd_i    (jq_rd),
    .status_o(jq_status)
  );

  // back: remainder unit and result register
  clp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .jq_i         (jq_status),
    .jq_rd_o      (jq_rd),
    .empty_o      (empty),
    .pop_i        (pop),
    .phase_valid_o(phase_valid_o),
    .phase_value_o(phase_value_o)
  );

endmodule

[rtl/clp_checker.sv]
`timescale 1ns / 1ps
// port-level checker of the clip launch phase tracker and its bind
module clp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        phase_valid_o,
  input logic [32:0] phase_value_o
);

  // a refused or non-query result carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !phase_valid_o) |-> (phase_value_o == 33'd0))
    else $error("invalid result with nonzero phase value");

  // a waiting result holds until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(phase_valid_o) && $stable(phase_value_o)))
    else $error("waiting result changed before pop");

  // out of reset both queues are empty
  assert property (@(posedge clk_i)
    !$past(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  // the input side fills up only through an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |=> (!full || $past(push)))
    else $error("full rose without a push");

endmodule

bind clip_launch_phase_tracker clp_checker u_clp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .phase_valid_o(phase_valid_o),
  .phase_value_o(phase_value_o)
);

[tb/sv/clip_launch_phase_tracker_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the clip launch phase tracker: directed table, then random traffic
module clip_launch_phase_tracker_tb;
  import clp_pkg::*;

  localparam int unsigned TRACKS          = 4;
  localparam int unsigned SLOTS           = 8;
  localparam logic [7:0]  PAD_ROW_BASE    = 8'd92;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned MAX_SHOWN       = 10;
  localparam int unsigned END_SETTLE      = 60;
  localparam int unsigned TIMEOUT_NS      = 10_000_000;

  // per phase {queued channel, playing channel, session mode}, phase 0 in the low bits
  localparam logic [PHASES*16-1:0] CFG_PLAN = {
    {4'd1, 4'd0, 8'h00}, {4'd6, 4'd3, 8'h01}, {4'd15, 4'd15, 8'h80},
    {4'd9, 4'd9, 8'h5A}, {4'd15, 4'd0, 8'h00}, {4'd0, 4'd15, 8'hFF}
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  status;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [31:0] pulse;
    logic        running;
    logic [7:0]  mode;
    logic [1:0]  qtrack;
    logic [31:0] lstart;
    logic [31:0] llen;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [32:0] value;
  } phase_res_t;

  typedef struct packed {
    item_t      it;
    logic       given;
    phase_res_t want;
  } row_t;

  // dut ports
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        push;
  logic        full;
  logic [1:0]  command_i;
  logic [7:0]  status_byte_i;
  logic [7:0]  note_number_i;
  logic [7:0]  velocity_i;
  logic [31:0] pulse_count_i;
  logic        transport_running_i;
  logic [7:0]  ui_mode_i;
  logic [1:0]  query_track_i;
  logic [31:0] loop_start_i;
  logic [31:0] loop_length_i;
  logic        empty;
  logic        pop;
  logic        phase_valid_o;
  logic [32:0] phase_value_o;

  // predicted configuration and track state
  logic [3:0]  chan_queued;
  logic [3:0]  chan_playing;
  logic [7:0]  mode_session;
  logic        id_known  [TRACKS];
  logic        playing   [TRACKS];
  logic [2:0]  play_slot [TRACKS];
  logic        anchor_ok [TRACKS];
  logic [31:0] anchor_at [TRACKS];
  logic        pend_ok   [TRACKS];
  logic [2:0]  pend_slot [TRACKS];
  logic        stop_seen [TRACKS];

  phase_res_t  phase_q [$];
  row_t        dir_rows [$];
  int unsigned err_count = 0;
  int unsigned burst_left = 0;
  logic [31:0] song_pulse = '0;
  logic [15:0] pop_mask = '1;
  logic [5:0]  pop_tick = '0;

  clip_launch_phase_tracker #(
    .TRACK_COUNT(TRACKS),
    .SLOT_COUNT (SLOTS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .push               (push),
    .full               (full),
    .command_i          (command_i),
    .status_byte_i      (status_byte_i),
    .note_number_i      (note_number_i),
    .velocity_i         (velocity_i),
    .pulse_count_i      (pulse_count_i),
    .transport_running_i(transport_running_i),
    .ui_mode_i          (ui_mode_i),
    .query_track_i      (query_track_i),
    .loop_start_i       (loop_start_i),
    .loop_length_i      (loop_length_i),
    .empty              (empty),
    .pop                (pop),
    .phase_valid_o      (phase_valid_o),
    .phase_value_o      (phase_value_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // hard stop if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void log_error(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("[%0t] %s", $time, msg);
  endfunction

  // stimulus builders for the directed table
  function automatic item_t led_item(input logic [7:0] status, input logic [7:0] note,
                                     input logic [7:0] vel, input logic [31:0] pulse,
                                     input logic running, input logic [7:0] mode);
    item_t it;
    it = '0;
    it.command = CMD_LED;
    it.status  = status;
    it.note    = note;
    it.vel     = vel;
    it.pulse   = pulse;
    it.running = running;
    it.mode    = mode;
    return it;
  endfunction

  function automatic item_t query_item(input logic [1:0] track, input logic [31:0] pulse,
                                       input logic [31:0] lstart, input logic [31:0] llen);
    item_t it;
    it = '0;
    it.command = CMD_QUERY;
    it.qtrack  = track;
    it.pulse   = pulse;
    it.lstart  = lstart;
    it.llen    = llen;
    return it;
  endfunction

  function automatic item_t bare_item(input logic [1:0] cmd, input logic fill);
    item_t it;
    it = fill ? '1 : '0;
    it.command = cmd;
    return it;
  endfunction

  function automatic row_t row_zero(input item_t it);
    row_t r;
    r.it = it;
    r.given = 1'b1;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t row_typed(input item_t it, input logic v, input logic [32:0] val);
    row_t r;
    r.it = it;
    r.given = 1'b1;
    r.want.valid = v;
    r.want.value = val;
    return r;
  endfunction

  function automatic row_t row_model(input item_t it);
    row_t r;
    r.it = it;
    r.given = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // phase predictor: applies one transaction to the track state, returns its result
  task automatic track_step(input item_t it, output phase_res_t res);
    logic [3:0]  ch;
    logic        on;
    logic        is_note;
    logic        queued_hit;
    logic        changed;
    logic [31:0] diff;
    logic [39:0] elapsed;
    logic [63:0] rem;
    int          t;
    int          s;
    res = '0;
    case (it.command)
      CMD_LED: begin
        ch = it.status[3:0];
        is_note = (it.status[7:4] == STATUS_NOTE_ON) || (it.status[7:4] == STATUS_NOTE_OFF);
        on = (it.status[7:4] == STATUS_NOTE_ON) && (it.vel != 8'd0);
        t = (int'(PAD_TOP_NOTE) - int'(it.note)) / 8;
        s = int'(it.note) - (int'(PAD_ROW_BASE) - 8 * t);
        if (is_note && it.mode == mode_session && it.note <= PAD_TOP_NOTE &&
            t < TRACKS && s >= 0 && s < SLOTS) begin
          if (ch == chan_queued) begin
            // queued channel wins when both channels match
            if (on) begin
              pend_ok[t] = 1'b1;
              pend_slot[t] = 3'(s);
            end
          end else if (ch == chan_playing) begin
            if (on) begin
              queued_hit = pend_ok[t] && (pend_slot[t] == 3'(s));
              changed = !id_known[t] || !playing[t] || (play_slot[t] != 3'(s));
              id_known[t] = 1'b1;
              playing[t] = 1'b1;
              play_slot[t] = 3'(s);
              if (it.running && (queued_hit || stop_seen[t])) begin
                anchor_ok[t] = 1'b1;
                anchor_at[t] = it.pulse;
              end else if (changed) begin
                anchor_ok[t] = 1'b0;
              end
              pend_ok[t] = 1'b0;
              stop_seen[t] = 1'b0;
            end else if (id_known[t] && playing[t] && play_slot[t] == 3'(s)) begin
              playing[t] = 1'b0;
              anchor_ok[t] = 1'b0;
              stop_seen[t] = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        for (int k = 0; k < TRACKS; k++) begin
          pend_ok[k] = 1'b0;
          stop_seen[k] = 1'b0;
          anchor_ok[k] = id_known[k] && playing[k];
          if (id_known[k] && playing[k]) anchor_at[k] = '0;
        end
      end
      CMD_QUERY: begin
        t = int'(it.qtrack);
        if (t < TRACKS && id_known[t] && playing[t] && anchor_ok[t] &&
            it.llen != 32'd0 && it.pulse >= anchor_at[t]) begin
          diff = it.pulse - anchor_at[t];
          elapsed = {diff, 8'h00};
          rem = 64'(elapsed) % 64'(it.llen);
          res.valid = 1'b1;
          res.value = 33'(it.lstart) + 33'(rem);
        end
      end
      default: ;
    endcase
  endtask

  // random transaction, mostly well-formed launch sequences for the current settings
  task automatic make_item(output item_t it);
    int unsigned pick;
    int          t;
    int          s;
    it = '0;
    pick = $urandom_range(0, 99);
    t = $urandom_range(0, TRACKS - 1);
    s = $urandom_range(0, SLOTS - 1);
    it.command = CMD_LED;
    it.pulse   = song_pulse;
    it.running = ($urandom_range(0, 9) != 0);
    it.mode    = ($urandom_range(0, 19) != 0) ? mode_session : 8'($urandom);
    if (pick < 20) begin
      // queued launch
      it.status = {STATUS_NOTE_ON, chan_queued};
      it.vel = 8'($urandom_range(1, 255));
    end else if (pick < 45) begin
      // launch on the playing channel, often the queued slot
      if ($urandom_range(0, 1) != 0) s = int'(pend_slot[t]);
      it.status = {STATUS_NOTE_ON, chan_playing};
      it.vel = 8'($urandom_range(1, 255));
    end else if (pick < 57) begin
      // stop, mostly of the slot that plays
      if ($urandom_range(0, 3) != 0) s = int'(play_slot[t]);
      if ($urandom_range(0, 1) != 0) begin
        it.status = {STATUS_NOTE_OFF, chan_playing};
        it.vel = 8'($urandom);
      end else begin
        it.status = {STATUS_NOTE_ON, chan_playing};
        it.vel = 8'd0;
      end
    end else if (pick < 61) begin
      it = bare_item(CMD_START, 1'b0);
      it.lstart = $urandom;
      it.status = 8'($urandom);
    end else if (pick < 88) begin
      it.command = CMD_QUERY;
      it.qtrack = 2'(t);
      it.lstart = $urandom;
      case ($urandom_range(0, 9))
        0:       it.llen = '0;
        1:       it.llen = $urandom;
        2:       it.llen = 32'd1;
        default: it.llen = $urandom_range(1, 24 * 256 * 16);
      endcase
      case ($urandom_range(0, 9))
        0:       it.pulse = $urandom;
        1:       it.pulse = anchor_at[t] - 32'd1;
        default: ;
      endcase
    end else if (pick < 92) begin
      it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.command = CMD_UNUSED;
    end else begin
      // noise on the led message path
      it.status = 8'($urandom);
      it.note   = 8'($urandom);
      it.vel    = 8'($urandom);
      it.mode   = 8'($urandom);
      it.pulse  = $urandom;
    end
    if (pick < 57) it.note = 8'(int'(PAD_ROW_BASE) - 8 * t + s);
  endtask

  // one input transaction; prediction taken at the accepting edge
  task automatic push_item(input item_t it, input logic given, input phase_res_t want);
    phase_res_t pred;
    @(negedge clk_i);
    push                <= 1'b1;
    command_i           <= it.command;
    status_byte_i       <= it.status;
    note_number_i       <= it.note;
    velocity_i          <= it.vel;
    pulse_count_i       <= it.pulse;
    transport_running_i <= it.running;
    ui_mode_i           <= it.mode;
    query_track_i       <= it.qtrack;
    loop_start_i        <= it.lstart;
    loop_length_i       <= it.llen;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    track_step(it, pred);
    phase_q.push_back(given ? want : pred);
  endtask

  task automatic hold_push(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // sender bursts with random gaps, long bursts now and then
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
      hold_push(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30));
    end
    burst_left--;
  endtask

  task automatic wait_idle(input int unsigned settle);
    hold_push(1);
    while (phase_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_QUEUED_CH:  chan_queued  = data[3:0];
      REG_PLAYING_CH: chan_playing = data[3:0];
      REG_MODE_CODE:  mode_session = data;
      default: ;
    endcase
  endtask

  // result receiver: stall pattern rerolled each time the 6-bit tick counter wraps
  initial pop = 1'b0;
  always @(negedge clk_i) begin
    pop_tick <= pop_tick + 6'd1;
    if (pop_tick == 6'd0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pop_mask <= '1;
        3, 4, 5: pop_mask <= 16'($urandom);
        6, 7:    pop_mask <= 16'($urandom) & 16'($urandom);
        8:       pop_mask <= 16'($urandom) | 16'($urandom);
        default: pop_mask <= '0;
      endcase
    end
    pop <= pop_mask[pop_tick[3:0]];
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    phase_res_t want;
    if (rst_ni && pop && !empty) begin
      if (phase_q.size() == 0) begin
        log_error($sformatf("unexpected result valid=%0b value=%h",
                            phase_valid_o, phase_value_o));
      end else begin
        want = phase_q.pop_front();
        if (phase_valid_o !== want.valid)
          log_error($sformatf("phase_valid: expected %0b, got %0b", want.valid, phase_valid_o));
        if (phase_value_o !== want.value)
          log_error($sformatf("phase_value: expected %h, got %h", want.value, phase_value_o));
      end
    end
  end

  // main sequence
  initial begin
    item_t      it;
    logic [15:0] plan;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = '0;
    cfg_data_i          = '0;
    push                = 1'b0;
    command_i           = '0;
    status_byte_i       = '0;
    note_number_i       = '0;
    velocity_i          = '0;
    pulse_count_i       = '0;
    transport_running_i = 1'b0;
    ui_mode_i           = '0;
    query_track_i       = '0;
    loop_start_i        = '0;
    loop_length_i       = '0;

    chan_queued  = QUEUED_CH_RST;
    chan_playing = PLAYING_CH_RST;
    mode_session = MODE_CODE_RST;
    for (int k = 0; k < TRACKS; k++) begin
      id_known[k]  = 1'b0;
      playing[k]   = 1'b0;
      play_slot[k] = '0;
      anchor_ok[k] = 1'b0;
      anchor_at[k] = '0;
      pend_ok[k]   = 1'b0;
      pend_slot[k] = '0;
      stop_seen[k] = 1'b0;
    end

    // directed table, reset settings: queued channel 1, playing channel 0, mode 0
    // nothing known right after reset
    dir_rows.push_back(row_zero(query_item(2'd0, 32'd0, 32'd0, 32'd1)));
    dir_rows.push_back(row_zero(bare_item(CMD_UNUSED, 1'b1)));
    dir_rows.push_back(row_zero(bare_item(CMD_START, 1'b0)));
    // queued then launched on track 0 slot 0: anchored at 1000
    dir_rows.push_back(row_zero(led_item(8'h91, 8'd92, 8'd127, 32'd900, 1'b1, 8'h00)));
    dir_rows.push_back(row_zero(led_item(8'h90, 8'd92, 8'd1, 32'd1000, 1'b1, 8'h00)));
    dir_rows.push_back(row_typed(query_item(2'd0, 32'd1000, '1, '1), 1'b1, 33'h0_FFFF_FFFF));
    // refusals (pulse below anchor, zero loop length, unknown track) and one answered query at the top pulse
    dir_rows.push_back(row_zero(query_item(2'd0, 32'd999, 32'd5, 32'd100)));
    dir_rows.push_back(row_zero(query_item(2'd0, 32'd2000, 32'd5, 32'd0)));
    dir_rows.push_back(row_model(query_item(2'd0, '1, '1, 32'h8000_0001)));
    dir_rows.push_back(row_zero(query_item(2'd3, 32'd2000, 32'd0, 32'd100)));
    // stop by note-off status, then relaunch after the witnessed stop
    dir_rows.push_back(row_zero(led_item(8'h80, 8'd92, 8'd64, 32'd3000, 1'b1, 8'h00)));
    dir_rows.push_back(row_zero(query_item(2'd0, 32'd3000, 32'd0, 32'd100)));
    dir_rows.push_back(row_zero(led_item(8'h90, 8'd95, 8'd127, 32'd5000, 1'b1, 8'h00)));
    dir_rows.push_back(row_model(query_item(2'd0, 32'd5024, 32'h100, 32'd24576)));
    // stop by note-on with zero velocity
    dir_rows.push_back(row_zero(led_item(8'h90, 8'd95, 8'd0, 32'd6000, 1'b1, 8'h00)));
    // track 3 launched with transport stopped, then anchored by transport start
    dir_rows.push_back(row_zero(led_item(8'h91, 8'd68, 8'd255, 32'd100, 1'b1, 8'h00)));
    dir_rows.push_back(row_zero(led_item(8'h90, 8'd68, 8'd9, 32'd200, 1'b0, 8'h00)));
    dir_rows.push_back(row_model(query_item(2'd3, 32'd300, 32'd0, 32'd1000)));
    dir_rows.push_back(row_zero(bare_item(CMD_START, 1'b0)));
    dir_rows.push_back(row_model(query_item(2'd3, '1, 32'd0, 32'd7)));
    // ignored messages: wrong status type, off-grid notes, mode mismatch, other channel
    dir_rows.push_back(row_zero(led_item(8'hA0, 8'd92, 8'd100, 32'd0, 1'b1, 8'h00)));
    dir_rows.push_back(row_zero(led_item(8'h90, 8'd100, 8'd100, 32'd0, 1'b1, 8'h00)));
    dir_rows.push_back(row_zero(led_item(8'h90, 8'd67, 8'd100, 32'd0, 1'b1, 8'h00)));
    dir_rows.push_back(row_zero(led_item(8'h90, 8'd99, 8'd100, 32'd0, 1'b1, 8'hFF)));
    dir_rows.push_back(row_zero(led_item(8'h92, 8'd99, 8'd100, 32'd0, 1'b1, 8'h00)));
    dir_rows.push_back(row_model(query_item(2'd0, 32'd7000, 32'd0, 32'd4096)));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      pace();
      push_item(dir_rows[i].it, dir_rows[i].given, dir_rows[i].want);
    end

    // random traffic under each register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle(4);
      plan = CFG_PLAN[ph*16 +: 16];
      cfg_write(REG_QUEUED_CH, {4'($urandom), plan[15:12]});
      cfg_write(REG_PLAYING_CH, {4'($urandom), plan[11:8]});
      cfg_write(REG_MODE_CODE, plan[7:0]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender holds off once until the block has drained
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) wait_idle(0);
        song_pulse = song_pulse + 32'($urandom_range(0, 30));
        if ($urandom_range(0, 49) == 0) song_pulse = $urandom;
        make_item(it);
        pace();
        push_item(it, 1'b0, '0);
      end
    end

    wait_idle(END_SETTLE);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
